>>> design/mtmi_pkg.sv
// Shared types and codes for the millisecond to month index converter.
package mtmi_pkg;

   typedef enum logic {
      CMD_TO_MONTH  = 1'b0,
      CMD_TO_BOUNDS = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_TIME_OOR  = 2'd1,
      STATUS_MONTH_OOR = 2'd2,
      STATUS_UNUSED    = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CSR_BASE_YEAR = 2'd0,
      CSR_MAX_MONTH = 2'd1,
      CSR_MIN_TIME  = 2'd2,
      CSR_MAX_TIME  = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic        cmd;
      logic [47:0] stamp_ms;
      logic [16:0] month_in;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [16:0] month_out;
      logic [47:0] start_ms;
      logic [47:0] end_ms;
   } rsp_type;

   localparam logic [13:0] BASE_YEAR_RST = 14'd1970;
   localparam logic [16:0] MAX_MONTH_RST = 17'd96359;
   localparam logic [47:0] MIN_TIME_RST  = 48'd0;
   localparam logic [47:0] MAX_TIME_RST  = 48'd253402300799999;

endpackage

>>> design/millis_to_month_index_converter.sv
// Top level: pipelined conversion between Unix millisecond stamps and month indexes.
//
// Request channel (req_valid, req_stall, req_data): cmd 0 takes a stamp and returns
// the month index counted from January of base_year, cmd 1 takes a month index and
// returns its first and last millisecond. Response channel (rsp_valid, rsp_stall,
// rsp_data) carries one response per request, in request order.
// Configuration: csr_we writes csr_wdata into register csr_index (base year,
// largest month, lowest and highest accepted stamp); write only while idle.
// One request can enter every cycle while no response is held by rsp_stall. The
// depth is set by the day-count division (four stages of six quotient bits)
// followed by the civil-date chain.
// The pipeline advances as a whole: while a response is held by rsp_stall the
// whole pipeline holds and req_stall is raised, so nothing is lost or repeated.
// Reset (synchronous) empties the pipeline and reloads the register defaults.
module millis_to_month_index_converter
   import mtmi_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [47:0] csr_wdata
);

   localparam int NS = 12;

   localparam logic [17:0] DAY_DIV  = 18'd84375;  // 86,400,000 >> 10
   localparam logic [22:0] M_ERA = 23'(((64'd1 << 40) + 64'd146096) / 64'd146097);
   localparam logic [17:0] M_Q1  = 18'(((64'd1 << 28) + 64'd1459) / 64'd1460);
   localparam logic [17:0] M_Q2  = 18'(((64'd1 << 33) + 64'd36523) / 64'd36524);
   localparam logic [17:0] M_Q3  = 18'(((64'd1 << 35) + 64'd146095) / 64'd146096);
   localparam logic [17:0] M_Y   = 18'(((64'd1 << 26) + 64'd364) / 64'd365);
   localparam logic [11:0] M_MP  = 12'(((64'd1 << 19) + 64'd152) / 64'd153);
   localparam logic [17:0] M_12  = 18'(((64'd1 << 21) + 64'd11) / 64'd12);
   localparam logic [15:0] M_400 = 16'(((64'd1 << 24) + 64'd399) / 64'd400);

   typedef struct packed {
      logic               cmd;
      logic               win_bad;
      logic               m_bad;
      logic [16:0]        midx;
      logic [17:0]        rem;
      logic [23:0]        num;
      logic [23:0]        quo;
      logic [21:0]        sday;
      logic [4:0]         era;
      logic [17:0]        doe;
      logic [6:0]         q1;
      logic [2:0]         q2;
      logic               q3;
      logic [8:0]         yoe;
      logic [8:0]         doy;
      logic [3:0]         month;
      logic [13:0]        year;
      logic [13:0]        yq0;
      logic [13:0]        yq1;
      logic [3:0]         mon0;
      logic [3:0]         mon1;
      logic [14:0]        yy0;
      logic [14:0]        yy1;
      logic [6:0]         ea0;
      logic [6:0]         ea1;
      logic [8:0]         yoe0;
      logic [8:0]         yoe1;
      logic [17:0]        doe0;
      logic [17:0]        doe1;
      logic signed [24:0] d0;
      logic signed [24:0] d1;
      logic               neg;
      logic [47:0]        s_ms;
      logic [49:0]        e_full;
      logic               b_bad;
      logic [47:0]        start_v;
      logic [47:0]        end_v;
      rsp_type            rsp;
   } work_type;

   logic [13:0] base_year_ff;
   logic [16:0] max_month_ff;
   logic [47:0] min_time_ff;
   logic [47:0] max_time_ff;

   work_type          pipe_ff [NS];
   work_type          pipe_in [NS];
   logic [NS-1:0]     vld_ff;
   logic              adv;

   // day of the March-based year on which month mp starts
   function automatic logic [8:0] doy_of(input logic [3:0] mp);
      logic [8:0] d;
      unique case (mp)
         4'd0:    d = 9'd0;
         4'd1:    d = 9'd31;
         4'd2:    d = 9'd61;
         4'd3:    d = 9'd92;
         4'd4:    d = 9'd122;
         4'd5:    d = 9'd153;
         4'd6:    d = 9'd184;
         4'd7:    d = 9'd214;
         4'd8:    d = 9'd245;
         4'd9:    d = 9'd275;
         4'd10:   d = 9'd306;
         4'd11:   d = 9'd337;
         default: d = 9'd0;
      endcase
      return d;
   endfunction

   function automatic logic [1:0] cent_of(input logic [8:0] y);
      logic [1:0] c;
      priority if (y >= 9'd300) c = 2'd3;
      else if (y >= 9'd200)     c = 2'd2;
      else if (y >= 9'd100)     c = 2'd1;
      else                      c = 2'd0;
      return c;
   endfunction

   // day of era for the first day of month mon (0 = January) in year of era y
   function automatic logic [17:0] first_doe(input logic [8:0] y, input logic [3:0] mon);
      logic [3:0] mp;
      mp = (mon >= 4'd2) ? mon - 4'd2 : mon + 4'd10;
      return 18'(y) * 18'd365 + 18'(y[8:2]) - 18'(cent_of(y)) + 18'(doy_of(mp));
   endfunction

   function automatic logic [13:0] div12(input logic [17:0] v);
      logic [35:0] p;
      p = v * M_12;
      return p[34:21];
   endfunction

   function automatic logic [6:0] div400(input logic [14:0] v);
      logic [30:0] p;
      p = v * M_400;
      return p[30:24];
   endfunction

   assign adv       = !(vld_ff[NS-1] && rsp_stall);
   assign req_stall = !adv;
   assign rsp_valid = vld_ff[NS-1];
   assign rsp_data  = pipe_ff[NS-1].rsp;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_year_ff <= BASE_YEAR_RST;
         max_month_ff <= MAX_MONTH_RST;
         min_time_ff  <= MIN_TIME_RST;
         max_time_ff  <= MAX_TIME_RST;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_BASE_YEAR: base_year_ff <= csr_wdata[13:0];
            CSR_MAX_MONTH: max_month_ff <= csr_wdata[16:0];
            CSR_MIN_TIME:  min_time_ff  <= csr_wdata;
            CSR_MAX_TIME:  max_time_ff  <= csr_wdata;
            default:       base_year_ff <= base_year_ff;
         endcase
      end
   end

   always_comb begin
      logic [17:0]        r;
      logic [23:0]        n;
      logic [23:0]        q;
      logic [17:0]        idx1;
      logic [44:0]        pera;
      logic [35:0]        pq;
      logic [17:0]        t;
      logic [10:0]        v;
      logic [22:0]        pmp;
      logic [3:0]         mp;
      logic [24:0]        u;
      logic [49:0]        e;
      logic signed [19:0] idx;
      work_type           w;

      // stage 0: request register, window and month limit checks
      w          = '0;
      w.cmd      = req_data.cmd;
      w.midx     = req_data.month_in;
      w.win_bad  = (req_data.stamp_ms < min_time_ff) || (req_data.stamp_ms > max_time_ff);
      w.m_bad    = req_data.month_in > max_month_ff;
      w.rem      = 18'(req_data.stamp_ms[47:34]);
      w.num      = req_data.stamp_ms[33:10];
      pipe_in[0] = w;

      // stages 1-4: day count, six quotient bits per stage
      for (int k = 1; k <= 4; k++) begin
         w = pipe_ff[k-1];
         r = w.rem;
         n = w.num;
         q = w.quo;
         for (int j = 0; j < 6; j++) begin
            r = {r[16:0], n[23]};
            n = {n[22:0], 1'b0};
            if (r >= DAY_DIV) begin
               r = r - DAY_DIV;
               q = {q[22:0], 1'b1};
            end else begin
               q = {q[22:0], 1'b0};
            end
         end
         w.rem      = r;
         w.num      = n;
         w.quo      = q;
         pipe_in[k] = w;
      end

      // month index side: year and month of index and index+1
      idx1           = 18'(pipe_ff[0].midx) + 18'd1;
      pipe_in[1].yq0 = div12(18'(pipe_ff[0].midx));
      pipe_in[1].yq1 = div12(idx1);

      w    = pipe_ff[1];
      idx1 = 18'(w.midx) + 18'd1;
      pipe_in[2].mon0 = 4'(18'(w.midx) - 18'(w.yq0) * 18'd12);
      pipe_in[2].mon1 = 4'(idx1 - 18'(w.yq1) * 18'd12);
      pipe_in[2].yy0  = 15'(base_year_ff) + 15'(w.yq0) + 15'd400
                        - 15'(pipe_in[2].mon0 < 4'd2);
      pipe_in[2].yy1  = 15'(base_year_ff) + 15'(w.yq1) + 15'd400
                        - 15'(pipe_in[2].mon1 < 4'd2);

      pipe_in[3].ea0 = div400(pipe_ff[2].yy0);
      pipe_in[3].ea1 = div400(pipe_ff[2].yy1);

      w = pipe_ff[3];
      pipe_in[4].yoe0 = 9'(w.yy0 - 15'(w.ea0) * 15'd400);
      pipe_in[4].yoe1 = 9'(w.yy1 - 15'(w.ea1) * 15'd400);

      // stage 5: era of the day count; day of era of the first day of both months
      w      = pipe_ff[4];
      w.sday = w.quo[21:0] + 22'd719468;
      pera   = w.sday * M_ERA;
      w.era  = pera[44:40];
      w.doe0 = first_doe(w.yoe0, w.mon0);
      w.doe1 = first_doe(w.yoe1, w.mon1);
      pipe_in[5] = w;

      // stage 6: day of era; day numbers of both month starts
      w     = pipe_ff[5];
      w.doe = 18'(w.sday - 22'(w.era) * 22'd146097);
      u     = 25'(w.ea0) * 25'd146097 + 25'(w.doe0);
      w.d0  = signed'(u) - 25'sd865565;
      u     = 25'(w.ea1) * 25'd146097 + 25'(w.doe1);
      w.d1  = signed'(u) - 25'sd865565;
      pipe_in[6] = w;

      // stage 7: leap corrections; month bounds in ms
      w        = pipe_ff[6];
      pq       = w.doe * M_Q1;
      w.q1     = pq[34:28];
      pq       = w.doe * M_Q2;
      w.q2     = pq[35:33];
      pq       = w.doe * M_Q3;
      w.q3     = pq[35];
      w.neg    = w.d0 < 25'sd0;
      w.s_ms   = 48'(50'(w.d0[22:0]) * 50'd86400000);
      w.e_full = 50'(w.d1[23:0]) * 50'd86400000;
      pipe_in[7] = w;

      // stage 8: year of era; bounds checks
      w         = pipe_ff[7];
      t         = w.doe - 18'(w.q1) + 18'(w.q2) - 18'(w.q3);
      pq        = t * M_Y;
      w.yoe     = pq[34:26];
      e         = w.e_full - 50'd1;
      w.b_bad   = w.m_bad || w.neg || (e[49:48] != 2'b00);
      w.start_v = w.s_ms;
      w.end_v   = e[47:0];
      pipe_in[8] = w;

      // stage 9: day of year
      w     = pipe_ff[8];
      w.doy = 9'(w.doe - (18'(w.yoe) * 18'd365 + 18'(w.yoe[8:2]) - 18'(cent_of(w.yoe))));
      pipe_in[9] = w;

      // stage 10: civil month and year
      w       = pipe_ff[9];
      v       = 11'(w.doy) * 11'd5 + 11'd2;
      pmp     = v * M_MP;
      mp      = pmp[22:19];
      w.month = (mp < 4'd10) ? mp + 4'd3 : mp - 4'd9;
      w.year  = 14'(w.yoe) + 14'(w.era) * 14'd400 + 14'(w.month <= 4'd2);
      pipe_in[10] = w;

      // stage 11: response
      w     = pipe_ff[10];
      idx   = (signed'({6'b0, w.year}) - signed'({6'b0, base_year_ff})) * 20'sd12
              + signed'({16'b0, w.month}) - 20'sd1;
      w.rsp = '0;
      if (w.cmd == CMD_TO_MONTH) begin
         if (w.win_bad) begin
            w.rsp.status = STATUS_TIME_OOR;
         end else if (idx < 20'sd0 || idx > signed'({3'b0, max_month_ff})) begin
            w.rsp.status = STATUS_MONTH_OOR;
         end else begin
            w.rsp.status    = STATUS_OK;
            w.rsp.month_out = idx[16:0];
         end
      end else begin
         if (w.b_bad) begin
            w.rsp.status = STATUS_MONTH_OOR;
         end else begin
            w.rsp.status   = STATUS_OK;
            w.rsp.start_ms = w.start_v;
            w.rsp.end_ms   = w.end_v;
         end
      end
      pipe_in[11] = w;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[NS-2:0], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < NS; k++) begin
            pipe_ff[k] <= pipe_in[k];
         end
      end
   end

`ifndef SYNTHESIS
   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> $stable(vld_ff))
      else $error("pipeline moved while response stalled");

   a_unused_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != STATUS_OK) |->
         (rsp_data.month_out == 17'd0 && rsp_data.start_ms == 48'd0 &&
          rsp_data.end_ms == 48'd0))
      else $error("result fields not cleared on error status");

   a_bounds_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == STATUS_OK && rsp_data.end_ms != 48'd0) |->
         (rsp_data.end_ms > rsp_data.start_ms && rsp_data.month_out == 17'd0))
      else $error("month bounds out of order");
`endif

endmodule
